### src/aabb_ct_pkg.sv
package aabb_ct_pkg;

    localparam int COORD_W = 16;
    localparam int EXT_W   = 15;
    localparam int SUM_W   = COORD_W + 4;
    localparam int FUNC_W  = 2;
    localparam int USED_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLAMP  = 2'd3;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic [EXT_W-1:0]          box_w;
        logic [EXT_W-1:0]          box_h;
        logic signed [COORD_W-1:0] move_x;
        logic signed [COORD_W-1:0] move_y;
    } aabb_req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] clamped_x;
        logic signed [COORD_W-1:0] clamped_y;
        logic                      status;
        logic [USED_W-1:0]         entries_used;
    } aabb_rsp_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [EXT_W-1:0]   w;
        logic [EXT_W-1:0]   h;
    } aabb_entry_t;

    // Registered result of one entry evaluation
    typedef struct packed {
        logic hit;
        sum_t offx;
        sum_t offy;
    } aabb_eval_t;

    function automatic sum_t sext_coord(logic [COORD_W-1:0] v);
        return {{(SUM_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic sum_t zext_extent(logic [EXT_W-1:0] v);
        return {{(SUM_W-EXT_W){1'b0}}, v};
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(sum_t v);
        sum_t hi;
        sum_t lo;
        hi = sum_t'({1'b0, {(COORD_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            return hi[COORD_W-1:0];
        else if (v < lo)
            return lo[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

### src/aabb_ct_mem.sv
module aabb_ct_mem
    import aabb_ct_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [AW-1:0] wr_addr,
    input  aabb_entry_t wr_data,
    input  logic [AW-1:0] rd_addr,
    output aabb_entry_t rd_data
);

    aabb_entry_t mem [DEPTH];
    aabb_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/aabb_ct_eval.sv
module aabb_ct_eval
    import aabb_ct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  aabb_req_t   req,
    input  aabb_entry_t entry,
    output logic        match,
    output aabb_eval_t  result
);

    sum_t sx, sy, px, py, pxe, pye, sxw, syh, mx, my;
    logic ox, oy;
    aabb_eval_t result_next;
    logic       hit_reg;
    sum_t       offx_reg;
    sum_t       offy_reg;

    // Exact match of all four stored fields, used by remove
    assign match = (entry.x == req.box_x) && (entry.y == req.box_y) &&
                   (entry.w == req.box_w) && (entry.h == req.box_h);

    always_comb
    begin
        mx  = sext_coord(req.move_x);
        my  = sext_coord(req.move_y);
        sx  = sext_coord(req.box_x) + mx;
        sy  = sext_coord(req.box_y) + my;
        sxw = sx + zext_extent(req.box_w);
        syh = sy + zext_extent(req.box_h);
        px  = sext_coord(entry.x);
        py  = sext_coord(entry.y);
        pxe = px + zext_extent(entry.w);
        pye = py + zext_extent(entry.h);

        // Inclusive overlap: touching edges count
        ox = (pxe >= sx) && (sxw >= px);
        oy = (pye >= sy) && (syh >= py);

        result_next.hit  = en && ox && oy;
        result_next.offx = (sx >= px) ? (mx - (pxe - sx)) : (mx - (sxw - px));
        result_next.offy = (sy >= py) ? (my - (pye - sy)) : (my - (syh - py));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= result_next.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        offx_reg <= result_next.offx;
        offy_reg <= result_next.offy;
    end

    assign result = {hit_reg, offx_reg, offy_reg};

endmodule

### src/aabb_collision_table.sv
// Sequence: add walks the table for the lowest free slot and stops there; remove,
// check and clamp walk every entry, then drain the pipeline before the result.
// One transaction at a time: the next request is taken in the cycle after the
// result is loaded, and finish holds the result back while the response is stalled.
// The walk reads one table entry a cycle from the single entry memory port.
// Reset clears all valid bits, the entry count and the handshakes at once.
module aabb_collision_table
    import aabb_ct_pkg::*;
#(
    parameter int MAX_BOXES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  aabb_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output aabb_rsp_t rsp
);

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BOXES - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Sequencer and table bookkeeping
    logic [1:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [MAX_BOXES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 status_reg, status_next;
    logic                 hit_reg, hit_next;
    logic                 s1_vld_reg, s1_vld_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Payload held for the running transaction
    aabb_req_t            req_reg, req_next;
    logic [IDX_W-1:0]     s1_idx_reg, s1_idx_next;
    sum_t                 tx_reg, tx_next;
    sum_t                 ty_reg, ty_next;
    aabb_rsp_t            rsp_reg, rsp_next;

    logic                 is_query;
    logic                 mem_wr_en;
    aabb_entry_t          mem_wr_data;
    aabb_entry_t          mem_rd_data;
    logic                 eval_en;
    logic                 eval_match;
    aabb_eval_t           eval_res;
    logic                 rsp_free;

    assign is_query  = (req_reg.func == FUNC_CHECK) || (req_reg.func == FUNC_CLAMP);
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign mem_wr_data.x = req_reg.box_x;
    assign mem_wr_data.y = req_reg.box_y;
    assign mem_wr_data.w = req_reg.box_w;
    assign mem_wr_data.h = req_reg.box_h;

    // Store an add into the first free slot met by the walk
    assign mem_wr_en = (state_reg == ST_SCAN) && (req_reg.func == FUNC_ADD) &&
                       !valid_reg[idx_reg];

    // Only valid entries count; the stage-1 entry is the one read last cycle
    assign eval_en = s1_vld_reg && valid_reg[s1_idx_reg] && is_query;

    aabb_ct_mem #(
        .DEPTH (MAX_BOXES),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (idx_reg),
        .wr_data (mem_wr_data),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    aabb_ct_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (eval_en),
        .req    (req_reg),
        .entry  (mem_rd_data),
        .match  (eval_match),
        .result (eval_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        s1_vld_next    = 1'b0;
        s1_idx_next    = idx_reg;
        rsp_valid_next = rsp_valid_reg;
        req_next       = req_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        rsp_next       = rsp_reg;

        // Drop the result once the consumer takes it
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // Stage 1: clear every matching entry for remove
        if (s1_vld_reg && (req_reg.func == FUNC_REMOVE) &&
            valid_reg[s1_idx_reg] && eval_match)
        begin
            valid_next[s1_idx_reg] = 1'b0;
            count_next             = count_reg - CNT_ONE;
        end

        // Stage 2: fold overlapping entries into the running minimum
        if (eval_res.hit)
        begin
            hit_next = 1'b1;
            if (eval_res.offx < tx_reg)
            begin
                tx_next = eval_res.offx;
            end
            if (eval_res.offy < ty_reg)
            begin
                ty_next = eval_res.offy;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    idx_next    = '0;
                    status_next = 1'b0;
                    hit_next    = 1'b0;
                    tx_next     = sext_coord(req.move_x);
                    ty_next     = sext_coord(req.move_y);
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (req_reg.func == FUNC_ADD)
                begin
                    if (!valid_reg[idx_reg])
                    begin
                        valid_next[idx_reg] = 1'b1;
                        count_next          = count_reg + CNT_ONE;
                        state_next          = ST_FINISH;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        status_next = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_ONE;
                    end
                end
                else
                begin
                    // Advance the read address; data returns next cycle
                    s1_vld_next = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_ONE;
                    end
                end
            end
            ST_DRAIN:
            begin
                // Wait for the last entry to leave stage 1; stage 2 folds it as finish is entered
                if (!s1_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_next.hit          = hit_reg;
                    rsp_next.status       = status_reg;
                    rsp_next.entries_used = USED_W'(count_reg);
                    if (req_reg.func == FUNC_CLAMP)
                    begin
                        rsp_next.clamped_x = sat_coord(tx_reg);
                        rsp_next.clamped_y = sat_coord(ty_reg);
                    end
                    else
                    begin
                        rsp_next.clamped_x = '0;
                        rsp_next.clamped_y = '0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            status_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            s1_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            hit_reg       <= hit_next;
            s1_vld_reg    <= s1_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        s1_idx_reg <= s1_idx_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        rsp_reg    <= rsp_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
    else $error("entry count disagrees with valid bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_BOXES)
    else $error("entry count exceeds table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_FINISH))
    else $error("result raised outside finish");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!s1_vld_reg && !eval_res.hit))
    else $error("walk pipeline busy while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |=> (count_reg == $past(count_reg) + CNT_ONE))
    else $error("add stored without counting");
`endif

endmodule

### tb/aabb_collision_table_tb.sv
`timescale 1ns / 1ps

module aabb_collision_table_tb;
    import aabb_ct_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1700;
    // Idle time after the last response has been matched, before the summary.
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
    // No idling on either side while this many transactions are in the window.
    localparam int STEADY_FROM = 400;
    localparam int STEADY_TO   = 700;
    // Long receiver hold-off starts once this many requests have gone in.
    localparam int HOLD_AT     = 1200;
    localparam int HOLD_CYCLES = 200;

    // One entry of the send queue: a request, or a marker telling the sender
    // to hold off until every outstanding response has come back.
    typedef struct {
        aabb_req_t req;
        bit        pause;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    aabb_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    aabb_rsp_t rsp;

    pending_t  send_q[$];
    aabb_rsp_t rsp_due[$];

    // Shadow copy of the box table, kept in wide arithmetic so nothing wraps.
    longint    box_px[TABLE_DEPTH];
    longint    box_py[TABLE_DEPTH];
    longint    box_ew[TABLE_DEPTH];
    longint    box_eh[TABLE_DEPTH];
    bit        box_live[TABLE_DEPTH];

    // Counters shared between processes, apart from the mismatch count, are only
    // updated with nonblocking assignments so every reader sees the same value within a time step.
    int        n_predicted = 0;
    int        n_matched = 0;
    int        n_mismatch = 0;
    int        n_hit = 0;
    int        n_dropped = 0;
    int        peak_used = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    logic      steady;

    aabb_collision_table #(.MAX_BOXES(TABLE_DEPTH)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    assign steady = (n_predicted >= STEADY_FROM) && (n_predicted < STEADY_TO);

    // Saturate a wide offset to the signed coordinate range.
    function automatic logic [COORD_W-1:0] clip_coord(longint v);
        if (v > 32767)
            return 16'h7FFF;
        else if (v < -32768)
            return 16'h8000;
        else
            return v[COORD_W-1:0];
    endfunction

    // Apply one request to the shadow table and return the response it must give.
    function automatic aabb_rsp_t table_response(aabb_req_t r);
        aabb_rsp_t res;
        longint    bx, by, bw, bh, mx, my;
        longint    sx, sy, tx, ty, offx, offy;
        bit        placed;
        int        used;
        res = '0;
        bx = longint'($signed(r.box_x));
        by = longint'($signed(r.box_y));
        bw = longint'(r.box_w);
        bh = longint'(r.box_h);
        mx = longint'($signed(r.move_x));
        my = longint'($signed(r.move_y));
        case (r.func)
            FUNC_ADD:
            begin
                // Take the lowest free slot; a full table drops the box.
                placed = 1'b0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!placed && !box_live[i])
                    begin
                        box_px[i]   = bx;
                        box_py[i]   = by;
                        box_ew[i]   = bw;
                        box_eh[i]   = bh;
                        box_live[i] = 1'b1;
                        placed      = 1'b1;
                    end
                end
                res.status = !placed;
            end
            FUNC_REMOVE:
            begin
                // Clear every live copy that matches on all four fields.
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (box_live[i] && box_px[i] == bx && box_py[i] == by &&
                        box_ew[i] == bw && box_eh[i] == bh)
                        box_live[i] = 1'b0;
                end
            end
            default:
            begin
                sx = bx + mx;
                sy = by + my;
                tx = mx;
                ty = my;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (box_live[i] &&
                        box_px[i] + box_ew[i] >= sx && sx + bw >= box_px[i] &&
                        box_py[i] + box_eh[i] >= sy && sy + bh >= box_py[i])
                    begin
                        res.hit = 1'b1;
                        offx = (sx >= box_px[i]) ? mx - (box_px[i] + box_ew[i] - sx)
                                                 : mx - (sx + bw - box_px[i]);
                        offy = (sy >= box_py[i]) ? my - (box_py[i] + box_eh[i] - sy)
                                                 : my - (sy + bh - box_py[i]);
                        if (offx < tx)
                            tx = offx;
                        if (offy < ty)
                            ty = offy;
                    end
                end
                if (r.func == FUNC_CLAMP)
                begin
                    res.clamped_x = clip_coord(tx);
                    res.clamped_y = clip_coord(ty);
                end
            end
        endcase
        used = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            used += box_live[i];
        res.entries_used = USED_W'(used);
        return res;
    endfunction

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_mismatch++;
        end
    endtask

    // Mostly clustered values so boxes overlap, with a share of full-range
    // values and the two extremes.
    function automatic logic [COORD_W-1:0] pick_coord(int span);
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        else if (r < 20)
            return COORD_W'($urandom);
        else
            return COORD_W'($urandom_range(2 * span) - span);
    endfunction

    function automatic logic [EXT_W-1:0] pick_extent(int span);
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return $urandom_range(1) ? 15'h7FFF : 15'h0000;
        else if (r < 20)
            return EXT_W'($urandom);
        else
            return EXT_W'($urandom_range(span));
    endfunction

    task automatic queue_request(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] x,
                                 logic [COORD_W-1:0] y, logic [EXT_W-1:0] w,
                                 logic [EXT_W-1:0] h, logic [COORD_W-1:0] mx,
                                 logic [COORD_W-1:0] my);
        pending_t p;
        p.pause      = 1'b0;
        p.req.func   = f;
        p.req.box_x  = x;
        p.req.box_y  = y;
        p.req.box_w  = w;
        p.req.box_h  = h;
        p.req.move_x = mx;
        p.req.move_y = my;
        send_q.insert(send_q.size(), p);
    endtask

    task automatic queue_pause();
        pending_t p;
        p.pause = 1'b1;
        p.req   = '0;
        send_q.insert(send_q.size(), p);
    endtask

    // Request driver: hold the payload while stalled, otherwise advance to the
    // next queued transaction or idle at random. A pause marker keeps valid low
    // until every predicted response has been matched.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (send_q.size() != 0 && send_q[0].pause)
            begin
                req_valid <= 1'b0;
                if (!req_valid && n_matched == n_predicted)
                    void'(send_q.pop_front());
            end
            else if (send_q.size() != 0 && (steady || $urandom_range(99) >= 37))
            begin
                req_valid <= 1'b1;
                req       <= send_q[0].req;
                void'(send_q.pop_front());
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response stall: random idling, one long hold-off that lets the block fill
    // up and push back on its input, and a stretch with no stalls at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && n_predicted >= HOLD_AT)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            rsp_stall <= !steady && ($urandom_range(99) < 37);
        end
    end

    // Monitor: predict on every accepted request, check every accepted response
    // against the oldest prediction. Pop before push so an unexpected response
    // never pairs with a request taken in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        aabb_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response with no request outstanding: %h", rsp);
                    n_mismatch++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    check_field("hit", want.hit, rsp.hit);
                    check_field("clamped_x", $signed(want.clamped_x),
                                $signed(rsp.clamped_x));
                    check_field("clamped_y", $signed(want.clamped_y),
                                $signed(rsp.clamped_y));
                    check_field("status", want.status, rsp.status);
                    check_field("entries_used", want.entries_used, rsp.entries_used);
                    n_matched <= n_matched + 1;
                end
            end
            if (req_valid && !req_stall)
            begin
                want = table_response(req);
                rsp_due.insert(rsp_due.size(), want);
                n_predicted <= n_predicted + 1;
                n_hit       <= n_hit + want.hit;
                n_dropped   <= n_dropped + want.status;
                if (int'(want.entries_used) > peak_used)
                    peak_used <= int'(want.entries_used);
            end
        end
    end

    initial
    begin : stimulus
        aabb_req_t added[$];
        aabb_req_t pick;
        int        sel;
        int        idx;

        // Directed: empty-table query and clamp, remove with no match.
        queue_request(FUNC_CHECK, 16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd0, 16'sd0);
        queue_request(FUNC_CLAMP, 16'sd0, 16'sd0, 15'd10, 15'd10, 16'h8000, 16'h7FFF);
        queue_request(FUNC_REMOVE, 16'sd16, 16'sd16, 15'd32, 15'd32, 16'sd0, 16'sd0);
        // Extreme boxes and a duplicated pair.
        queue_request(FUNC_ADD, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF);
        queue_request(FUNC_ADD, 16'h7FFF, 16'h7FFF, 15'd0, 15'd0, 16'h7FFF, 16'h8000);
        queue_request(FUNC_ADD, 16'sd16, 16'sd16, 15'd32, 15'd32, 16'sd0, 16'sd0);
        queue_request(FUNC_ADD, 16'sd16, 16'sd16, 15'd32, 15'd32, 16'sd0, 16'sd0);
        // Touching an edge counts; one step past it does not.
        queue_request(FUNC_CHECK, 16'sd48, 16'sd16, 15'd5, 15'd5, 16'sd0, 16'sd0);
        queue_request(FUNC_CHECK, 16'sd49, 16'sd16, 15'd5, 15'd5, 16'sd0, 16'sd0);
        // Clamp far enough below the range to saturate, and one at the top.
        queue_request(FUNC_CLAMP, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 16'h8000, 16'h8000);
        queue_request(FUNC_CLAMP, 16'sd0, 16'sd0, 15'h7FFF, 15'h7FFF, 16'h7FFF, 16'h7FFF);
        // Fill the table, then one add that must be dropped.
        for (int i = 0; i < TABLE_DEPTH - 4; i++)
            queue_request(FUNC_ADD, COORD_W'(64 * i), COORD_W'(-40 * i),
                          EXT_W'(20 + i), EXT_W'(30 - i), 16'sd0, 16'sd0);
        queue_request(FUNC_ADD, 16'sd5, 16'sd5, 15'd5, 15'd5, 16'sd0, 16'sd0);
        // Remove both duplicates, refill the lowest free slot, then query the table.
        queue_request(FUNC_REMOVE, 16'sd16, 16'sd16, 15'd32, 15'd32, 16'sd0, 16'sd0);
        queue_request(FUNC_ADD, 16'sd100, 16'sd100, 15'd8, 15'd8, 16'sd0, 16'sd0);
        queue_request(FUNC_CLAMP, 16'sd40, -16'sd40, 15'd70, 15'd20, 16'sd12, -16'sd7);
        queue_pause();

        // Random: adds and removes keep the table churning, removes mostly
        // aim at boxes added earlier, queries cluster near the stored boxes.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(99);
            pick.move_x = COORD_W'($urandom);
            pick.move_y = COORD_W'($urandom);
            if (sel < 26)
            begin
                pick.func = FUNC_ADD;
                if (added.size() != 0 && $urandom_range(99) < 15)
                begin
                    idx = $urandom_range(added.size() - 1);
                    pick.box_x = added[idx].box_x;
                    pick.box_y = added[idx].box_y;
                    pick.box_w = added[idx].box_w;
                    pick.box_h = added[idx].box_h;
                end
                else
                begin
                    pick.box_x = pick_coord(600);
                    pick.box_y = pick_coord(600);
                    pick.box_w = pick_extent(400);
                    pick.box_h = pick_extent(400);
                end
                added.insert(added.size(), pick);
                if (added.size() > 24)
                    void'(added.pop_front());
            end
            else if (sel < 52)
            begin
                pick.func = FUNC_REMOVE;
                if (added.size() != 0 && $urandom_range(3) != 0)
                begin
                    idx = $urandom_range(added.size() - 1);
                    pick.box_x = added[idx].box_x;
                    pick.box_y = added[idx].box_y;
                    pick.box_w = added[idx].box_w;
                    pick.box_h = added[idx].box_h;
                    added.delete(idx);
                end
                else
                begin
                    pick.box_x = pick_coord(600);
                    pick.box_y = pick_coord(600);
                    pick.box_w = pick_extent(400);
                    pick.box_h = pick_extent(400);
                end
            end
            else
            begin
                pick.func   = (sel < 76) ? FUNC_CHECK : FUNC_CLAMP;
                pick.box_x  = pick_coord(600);
                pick.box_y  = pick_coord(600);
                pick.box_w  = pick_extent(200);
                pick.box_h  = pick_extent(200);
                pick.move_x = pick_coord(300);
                pick.move_y = pick_coord(300);
            end
            queue_request(pick.func, pick.box_x, pick.box_y, pick.box_w, pick.box_h,
                          pick.move_x, pick.move_y);
            if (n == RANDOM_ITEMS / 2)
                queue_pause();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge, away from every clocked update.
        do
            @(negedge clk);
        while (send_q.size() != 0 || req_valid || n_matched != n_predicted);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("%0d requests checked: %0d query hits, %0d adds dropped, peak %0d boxes",
                 n_predicted, n_hit, n_dropped, peak_used);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d of %0d responses back", n_matched, n_predicted);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
src/aabb_ct_pkg.sv
src/aabb_ct_mem.sv
src/aabb_ct_eval.sv
src/aabb_collision_table.sv
tb/aabb_collision_table_tb.sv
